// ----- sv/rcfd_pkg.sv -----
`timescale 1ns / 1ps

package rcfd_pkg;

    localparam int unsigned FRAME_LEN   = 3;
    localparam int unsigned SERVO_COUNT = 8;

    localparam logic [7:0] FRAME_DELIM      = 8'hFF;
    localparam logic [7:0] GRP_MOTOR        = 8'h00;
    localparam logic [7:0] GRP_SERVO        = 8'h01;
    localparam logic [7:0] GRP_IR_LEARN     = 8'h50;
    localparam logic [7:0] GRP_IR_SEND      = 8'h51;
    localparam logic [7:0] GRP_MODE         = 8'h13;
    localparam logic [7:0] ANGLE_LIMIT_RST  = 8'd180;

    localparam logic [7:0] MOTOR_STOP    = 8'h00;
    localparam logic [7:0] MOTOR_FORWARD = 8'h01;
    localparam logic [7:0] MOTOR_BACK    = 8'h02;
    localparam logic [7:0] MOTOR_LEFT    = 8'h03;
    localparam logic [7:0] MOTOR_RIGHT   = 8'h04;

    localparam logic [7:0] IR_TYPE_COUNT   = 8'd5;
    localparam logic [7:0] IR_NUMBER_COUNT = 8'd10;
    localparam logic [7:0] MODE_MAX        = 8'd4;
    localparam logic [7:0] LINK_ARG_ON     = 8'h00;
    localparam logic [7:0] LINK_ARG_OFF    = 8'h01;

    typedef logic [3:0] action_t;
    localparam action_t ACT_IGNORED  = 4'd0;
    localparam action_t ACT_STOP     = 4'd1;
    localparam action_t ACT_FORWARD  = 4'd2;
    localparam action_t ACT_BACK     = 4'd3;
    localparam action_t ACT_LEFT     = 4'd4;
    localparam action_t ACT_RIGHT    = 4'd5;
    localparam action_t ACT_SERVO    = 4'd6;
    localparam action_t ACT_IR_LEARN = 4'd7;
    localparam action_t ACT_IR_SEND  = 4'd8;
    localparam action_t ACT_MODE     = 4'd9;
    localparam action_t ACT_LINK_ON  = 4'd10;
    localparam action_t ACT_LINK_OFF = 4'd11;

    typedef logic [2:0] reply_t;
    localparam reply_t REPLY_NONE        = 3'd0;
    localparam reply_t REPLY_ACK_FORWARD = 3'd1;
    localparam reply_t REPLY_ACK_BACK    = 3'd2;
    localparam reply_t REPLY_LINK_ON     = 3'd3;
    localparam reply_t REPLY_LINK_OFF    = 3'd4;

endpackage

// ----- sv/robot_command_frame_decoder_top.sv -----
// The result is registered: it appears on the output register in the cycle after its closing byte is taken.
// Throughput: one received byte per cycle; input stalls only while a result waits unread.
// Reset (rst_n, asynchronous, active low): framing returns to waiting for a start byte,
// the mode, IR type and IR number clear, the link flag sets and the angle limit is 180.
// Frame byte storage is not reset; a decoded frame always writes all three bytes first.
`timescale 1ns / 1ps

module robot_command_frame_decoder_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [7:0]              cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              rx_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output rcfd_pkg::action_t       action,
    output logic [2:0]              servo_index,
    output logic [7:0]              servo_angle,
    output logic [2:0]              ir_type,
    output logic [3:0]              ir_number,
    output logic [2:0]              cruise_mode,
    output logic                    link_connected,
    output rcfd_pkg::reply_t        reply
);
    import rcfd_pkg::*;

    logic [7:0] angle_lim_reg;
    logic       in_frame_reg;
    logic [2:0] byte_count_reg;
    logic [7:0] frame_bytes_reg [FRAME_LEN];
    logic [2:0] mode_reg;
    logic       link_reg;
    logic [2:0] ir_type_reg;
    logic [3:0] ir_number_reg;

    logic       out_valid_reg;
    action_t    action_reg;
    logic [2:0] servo_index_reg;
    logic [7:0] servo_angle_reg;
    reply_t     reply_reg;

    logic       accept;
    logic       is_delim;
    logic       close_ok;
    logic [7:0] grp;
    logic [7:0] sel;
    logic [7:0] arg;

    action_t    action_next;
    reply_t     reply_next;
    logic [2:0] servo_index_next;
    logic [7:0] servo_angle_next;
    logic [2:0] mode_next;
    logic       link_next;
    logic [2:0] ir_type_next;
    logic [3:0] ir_number_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_delim = (rx_byte == FRAME_DELIM);
    assign close_ok = accept && in_frame_reg && is_delim &&
                      (byte_count_reg == 3'(FRAME_LEN));

    assign grp = frame_bytes_reg[0];
    assign sel = frame_bytes_reg[1];
    assign arg = frame_bytes_reg[2];

    always_comb
    begin
        action_next      = ACT_IGNORED;
        reply_next       = REPLY_NONE;
        servo_index_next = 3'd0;
        servo_angle_next = 8'd0;
        mode_next        = mode_reg;
        link_next        = link_reg;
        ir_type_next     = ir_type_reg;
        ir_number_next   = ir_number_reg;

        if (grp == GRP_MOTOR)
        begin
            unique case (sel)
                MOTOR_STOP:
                begin
                    action_next = ACT_STOP;
                end
                MOTOR_FORWARD:
                begin
                    action_next = ACT_FORWARD;
                    reply_next  = REPLY_ACK_FORWARD;
                end
                MOTOR_BACK:
                begin
                    action_next = ACT_BACK;
                    reply_next  = REPLY_ACK_BACK;
                end
                MOTOR_LEFT:
                begin
                    action_next = ACT_LEFT;
                end
                MOTOR_RIGHT:
                begin
                    action_next = ACT_RIGHT;
                end
                default:
                begin
                    action_next = ACT_IGNORED;
                end
            endcase
        end
        else if (grp == GRP_SERVO)
        begin
            if ((arg <= angle_lim_reg) && (sel >= 8'd1) && (sel <= 8'(SERVO_COUNT)))
            begin
                action_next      = ACT_SERVO;
                servo_index_next = 3'(sel - 8'd1);
                servo_angle_next = arg;
            end
        end
        else if ((grp == GRP_IR_LEARN) || (grp == GRP_IR_SEND))
        begin
            if ((sel < IR_TYPE_COUNT) && (arg < IR_NUMBER_COUNT))
            begin
                ir_type_next   = sel[2:0];
                ir_number_next = arg[3:0];
                action_next    = (grp == GRP_IR_LEARN) ? ACT_IR_LEARN : ACT_IR_SEND;
            end
        end
        else if (grp == GRP_MODE)
        begin
            action_next = ACT_MODE;
            if ((sel >= 8'd1) && (sel <= MODE_MAX))
            begin
                mode_next = sel[2:0];
            end
            else
            begin
                mode_next = 3'd0;
                if (sel == 8'h00)
                begin
                    if (arg == LINK_ARG_ON)
                    begin
                        link_next   = 1'b1;
                        action_next = ACT_LINK_ON;
                        reply_next  = REPLY_LINK_ON;
                    end
                    else if (arg == LINK_ARG_OFF)
                    begin
                        link_next   = 1'b0;
                        action_next = ACT_LINK_OFF;
                        reply_next  = REPLY_LINK_OFF;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_lim_reg  <= ANGLE_LIMIT_RST;
            in_frame_reg   <= 1'b0;
            byte_count_reg <= 3'd0;
            mode_reg       <= 3'd0;
            link_reg       <= 1'b1;
            ir_type_reg    <= 3'd0;
            ir_number_reg  <= 4'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                angle_lim_reg <= cfg_wdata;
            end

            if (accept)
            begin
                if (!in_frame_reg)
                begin
                    if (is_delim)
                    begin
                        in_frame_reg   <= 1'b1;
                        byte_count_reg <= 3'd0;
                    end
                end
                else if (is_delim)
                begin
                    in_frame_reg   <= 1'b0;
                    byte_count_reg <= 3'd0;
                end
                else if (byte_count_reg != 3'd7)
                begin
                    byte_count_reg <= byte_count_reg + 3'd1;
                end
            end

            if (close_ok)
            begin
                mode_reg      <= mode_next;
                link_reg      <= link_next;
                ir_type_reg   <= ir_type_next;
                ir_number_reg <= ir_number_next;
            end

            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg <= close_ok;
            end
        end
    end

    // Frame bytes and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept && in_frame_reg && !is_delim && (byte_count_reg < 3'(FRAME_LEN)))
        begin
            frame_bytes_reg[byte_count_reg[1:0]] <= rx_byte;
        end
        if (close_ok)
        begin
            action_reg      <= action_next;
            servo_index_reg <= servo_index_next;
            servo_angle_reg <= servo_angle_next;
            reply_reg       <= reply_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign servo_index    = servo_index_reg;
    assign servo_angle    = servo_angle_reg;
    assign ir_type        = ir_type_reg;
    assign ir_number      = ir_number_reg;
    assign cruise_mode    = mode_reg;
    assign link_connected = link_reg;
    assign reply          = reply_reg;

    a_open_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_frame_reg && is_delim) |=> (in_frame_reg && (byte_count_reg == 3'd0)))
        else $error("A start byte did not open a fresh frame.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept && in_frame_reg && is_delim))
        else $error("A result appeared without a closing byte being taken.");

    a_servo_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (action_reg != ACT_SERVO)) |->
            ((servo_index_reg == 3'd0) && (servo_angle_reg == 8'd0)))
        else $error("Servo fields are non-zero on a result that is not a servo item.");

    a_link_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (reply_reg == REPLY_LINK_ON)) |-> link_reg)
        else $error("A link-on reply was given while the link flag is clear.");

endmodule
